>>> rtl/sspm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided-slice maximum projection: shared types and constants
// Transaction payloads, configuration register indexes and default sizes
// used by the projection core and its users.
// ----------------------------------------------------------------------------
package sspm_pkg;

    // Default sizes of the frame store
    localparam int DEF_MAX_PIXELS = 65536;
    localparam int DEF_PIXEL_BITS = 16;

    // Field and register widths
    localparam int VOXEL_W  = 16;
    localparam int INDEX_W  = 16;
    localparam int SLICE_W  = 16;
    localparam int FRAME_W  = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SLICE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SLICE    = 2'd3;

    // Configuration reset values
    localparam logic [FRAME_W-1:0] RST_FRAME_PIXELS = 17'd65536;
    localparam logic [SLICE_W-1:0] RST_START_SLICE  = 16'd0;
    localparam logic [SLICE_W-1:0] RST_SLICE_STEP   = 16'd1;
    localparam logic [SLICE_W-1:0] RST_END_SLICE    = 16'd65535;

    // One input voxel
    typedef struct packed {
        logic [VOXEL_W-1:0] voxel_value;
        logic               volume_start;
    } t_in_item;

    // One projected pixel
    typedef struct packed {
        logic [VOXEL_W-1:0] projected_value;
        logic [INDEX_W-1:0] pixel_index;
        logic               final_slice;
        logic               last_pixel;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/strided_slice_max_projection_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided-slice maximum projection core
// Per-pixel running maximum over a selected set of slices of a voxel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Voxels enter on the input channel (i_in_valid / o_in_stall) in raster
//   order, slice after slice; volume_start marks the first voxel of a volume.
//   Only slices start, start+step, ... up to end are used. Each voxel of a
//   selected slice produces one transaction on the output channel
//   (o_out_valid / i_out_stall) carrying the running maximum of that pixel;
//   other voxels produce nothing.
//   A voxel passes the update stage and then the output register on its way
//   to output valid. Throughput is one voxel per cycle while the receiver
//   does not stall: each voxel costs one read-modify-write of the frame
//   store, read on acceptance and written back as the update stage advances,
//   with a forwarding path when consecutive voxels hit the same pixel.
//   While the receiver stalls, one result waits in the output register and
//   one more in the update stage; only then does o_in_stall rise.
//   Reset clears the counters and loads the configuration defaults. The
//   frame store is not cleared: the first selected slice overwrites it.
//   Configuration writes take effect at once, except the start slice, which
//   is loaded at the next volume start.
// ----------------------------------------------------------------------------
module strided_slice_max_projection_core #(
    parameter int MAX_PIXELS = sspm_pkg::DEF_MAX_PIXELS,
    parameter int PIXEL_BITS = sspm_pkg::DEF_PIXEL_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration port
    input  wire                               i_cfg_we,
    input  wire [sspm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [sspm_pkg::CFG_W-1:0]         i_cfg_data,
    // voxel input
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire sspm_pkg::t_in_item           i_in_data,
    // projection output
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output sspm_pkg::t_out_item               o_out_data
);
    import sspm_pkg::*;

    localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int FCAP = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;
    localparam logic [FRAME_W-1:0] FCAP_V   = FRAME_W'(FCAP);
    localparam logic [SLICE_W-1:0] SC_MAX   = {SLICE_W{1'b1}};

    // configuration registers
    logic [FRAME_W-1:0] r_frame_pixels;
    logic [SLICE_W-1:0] r_start_slice;
    logic [SLICE_W-1:0] r_slice_step;
    logic [SLICE_W-1:0] r_end_slice;

    // counters
    logic [INDEX_W-1:0] r_pixel_count, n_pixel_count;
    logic [SLICE_W-1:0] r_slice_count, n_slice_count;
    logic [FRAME_W-1:0] r_next_sel,    n_next_sel;
    logic               r_first_taken, n_first_taken;

    // frame store
    logic [PIXEL_BITS-1:0] r_mem [MAX_PIXELS];
    logic [PIXEL_BITS-1:0] r_rd_data;

    // update stage
    logic                  r_s1_v;
    logic [AW-1:0]         r_s1_addr;
    logic [PIXEL_BITS-1:0] r_s1_voxel;
    logic                  r_s1_first;
    logic [INDEX_W-1:0]    r_s1_idx;
    logic                  r_s1_final;
    logic                  r_s1_last;
    logic                  r_fwd_hit;
    logic [PIXEL_BITS-1:0] r_fwd_data;

    // output register
    logic                  r_out_v;
    t_out_item             r_out;

    // input-side decode
    logic [INDEX_W-1:0]    eff_pc;
    logic [SLICE_W-1:0]    eff_sc;
    logic [FRAME_W-1:0]    eff_ns;
    logic                  eff_ft;
    logic [FRAME_W-1:0]    fsize;
    logic [FRAME_W-1:0]    step;
    logic [FRAME_W:0]      nsum;
    logic                  slice_end;
    logic                  selected;
    logic                  final_sel;
    logic [AW-1:0]         addr;
    logic [PIXEL_BITS-1:0] voxel;
    logic                  in_acc;
    logic                  s1_adv;
    logic [PIXEL_BITS-1:0] s1_old;
    logic [PIXEL_BITS-1:0] s1_new;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= RST_FRAME_PIXELS;
            r_start_slice  <= RST_START_SLICE;
            r_slice_step   <= RST_SLICE_STEP;
            r_end_slice    <= RST_END_SLICE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data;
                CFG_START_SLICE:  r_start_slice  <= i_cfg_data[SLICE_W-1:0];
                CFG_SLICE_STEP:   r_slice_step   <= i_cfg_data[SLICE_W-1:0];
                CFG_END_SLICE:    r_end_slice    <= i_cfg_data[SLICE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the update stage moves on when the output register frees
    assign s1_adv     = r_s1_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_s1_v && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Decode the incoming voxel against the slice selection
    always_comb begin
        eff_pc = i_in_data.volume_start ? '0 : r_pixel_count;
        eff_sc = i_in_data.volume_start ? '0 : r_slice_count;
        eff_ns = i_in_data.volume_start ? FRAME_W'(r_start_slice) : r_next_sel;
        eff_ft = i_in_data.volume_start ? 1'b0 : r_first_taken;

        fsize = r_frame_pixels;
        if (fsize == '0) begin
            fsize = FRAME_W'(1);
        end
        if (fsize > FCAP_V) begin
            fsize = FCAP_V;
        end

        step = (r_slice_step == '0) ? FRAME_W'(1) : FRAME_W'(r_slice_step);
        nsum = {1'b0, eff_ns} + {1'b0, step};

        slice_end = ({1'b0, eff_pc} + FRAME_W'(1)) >= fsize;
        selected  = (FRAME_W'(eff_sc) == eff_ns) && (eff_sc <= r_end_slice);
        final_sel = nsum > (FRAME_W + 1)'(r_end_slice);
        addr      = AW'(eff_pc);
        voxel     = i_in_data.voxel_value[PIXEL_BITS-1:0];

        n_pixel_count = slice_end ? '0 : eff_pc + INDEX_W'(1);
        n_slice_count = eff_sc;
        n_next_sel    = eff_ns;
        n_first_taken = eff_ft;
        if (slice_end) begin
            if (eff_sc < SC_MAX) begin
                n_slice_count = eff_sc + SLICE_W'(1);
            end
            if (selected) begin
                n_next_sel    = nsum[FRAME_W-1:0];
                n_first_taken = 1'b1;
            end
        end
    end

    // Advance the counters on every accepted voxel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= '0;
            r_slice_count <= '0;
            r_next_sel    <= FRAME_W'(RST_START_SLICE);
            r_first_taken <= 1'b0;
        end else if (in_acc) begin
            r_pixel_count <= n_pixel_count;
            r_slice_count <= n_slice_count;
            r_next_sel    <= n_next_sel;
            r_first_taken <= n_first_taken;
        end
    end

    // Frame store: read on selected acceptance, write back from the update stage
    always_ff @(posedge i_clk) begin
        if (in_acc && selected) begin
            r_rd_data <= r_mem[addr];
        end
        if (s1_adv) begin
            r_mem[r_s1_addr] <= s1_new;
        end
    end

    // Update stage: max (first slice: the voxel), forwarding a same-pixel write
    assign s1_old = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign s1_new = (!r_s1_first || (s1_old < r_s1_voxel)) ? r_s1_voxel : s1_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc && selected) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && selected) begin
            r_s1_addr  <= addr;
            r_s1_voxel <= voxel;
            r_s1_first <= eff_ft;
            r_s1_idx   <= eff_pc;
            r_s1_final <= final_sel;
            r_s1_last  <= final_sel && slice_end;
            r_fwd_hit  <= s1_adv && (r_s1_addr == addr);
            r_fwd_data <= s1_new;
        end
    end

    // Output register: load from the update stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.projected_value <= VOXEL_W'(s1_new);
            r_out.pixel_index     <= r_s1_idx;
            r_out.final_slice     <= r_s1_final;
            r_out.last_pixel      <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Checks
    a_stall_needs_busy_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_v)
        else $error("input stalled while update stage empty");

    a_pixel_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pixel_count} < FCAP_V)
        else $error("pixel count outside frame store");

    a_last_implies_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_last) |-> r_s1_final)
        else $error("last pixel flagged outside final slice");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_adv) |=> (r_s1_v && $stable(r_s1_addr)))
        else $error("update stage lost its entry while blocked");

endmodule
`default_nettype wire

>>> sim/strided_slice_max_projection_core_tb.sv
// ----------------------------------------------------------------------------
// Strided-slice maximum projection core testbench
// Streams voxel volumes through the core under changing slice selections and
// frame sizes, predicts every projected pixel from a private copy of the frame
// store and counters, and checks each output transaction field by field while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module strided_slice_max_projection_core_tb;
    import sspm_pkg::*;

    localparam int QUIET_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_FRAME_PIXELS;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    strided_slice_max_projection_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Projection state mirrored from the block
    bit [VOXEL_W-1:0] max_store [DEF_MAX_PIXELS];
    bit               store_written [DEF_MAX_PIXELS];
    logic [FRAME_W-1:0] cfg_frame = RST_FRAME_PIXELS;
    logic [SLICE_W-1:0] cfg_start = RST_START_SLICE;
    logic [SLICE_W-1:0] cfg_step  = RST_SLICE_STEP;
    logic [SLICE_W-1:0] cfg_end   = RST_END_SLICE;
    logic [INDEX_W-1:0] pix_cnt   = '0;
    logic [SLICE_W-1:0] slice_cnt = '0;
    logic [FRAME_W-1:0] next_sel  = FRAME_W'(RST_START_SLICE);
    bit                 first_done = 1'b0;

    t_out_item   projections_due[$];
    int          errors = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    // Advance the mirrored state by one voxel and queue the pixel it projects
    function automatic void project_voxel(input t_in_item it);
        int unsigned fsize, step, addr, v;
        bit slice_end, sel, fin;
        t_out_item res;
        v    = it.voxel_value & ((1 << DEF_PIXEL_BITS) - 1);
        step = (cfg_step == 0) ? 1 : int'(cfg_step);
        if (it.volume_start) begin
            pix_cnt    = '0;
            slice_cnt  = '0;
            next_sel   = FRAME_W'(cfg_start);
            first_done = 1'b0;
        end
        fsize = (cfg_frame == 0) ? 1 : int'(cfg_frame);
        if (fsize > DEF_MAX_PIXELS) fsize = DEF_MAX_PIXELS;
        if (fsize > 65536) fsize = 65536;
        slice_end = (pix_cnt + 1) >= fsize;
        sel = (slice_cnt == next_sel) && (slice_cnt <= cfg_end);
        if (sel) begin
            addr = pix_cnt % DEF_MAX_PIXELS;
            if (!first_done || max_store[addr] < v) begin
                max_store[addr]     = VOXEL_W'(v);
                store_written[addr] = 1'b1;
            end
            fin = (next_sel + step) > cfg_end;
            res.projected_value = max_store[addr];
            res.pixel_index     = pix_cnt;
            res.final_slice     = fin;
            res.last_pixel      = fin && slice_end;
            projections_due.push_back(res);
        end
        if (slice_end) begin
            pix_cnt = '0;
            if (slice_cnt < 16'hFFFF) slice_cnt = slice_cnt + 16'd1;
            if (sel) begin
                next_sel   = FRAME_W'(next_sel + step);
                first_done = 1'b1;
            end
        end else begin
            pix_cnt = pix_cnt + 16'd1;
        end
    endfunction

    // Offer one voxel, idling first at random; leave valid high afterwards
    task automatic send_voxel(input logic [VOXEL_W-1:0] value, input bit vol_start);
        t_in_item it;
        int unsigned addr;
        addr = pix_cnt % DEF_MAX_PIXELS;
        // restart the volume rather than compare against a never-written pixel
        if (!vol_start && first_done && !store_written[addr] &&
            slice_cnt == next_sel && slice_cnt <= cfg_end)
            vol_start = 1'b1;
        it.voxel_value  = value;
        it.volume_start = vol_start;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        project_voxel(it);
    endtask

    // Drop valid and hold until every projection has come back
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (projections_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_PIXELS: cfg_frame = data;
            CFG_START_SLICE:  cfg_start = data[SLICE_W-1:0];
            CFG_SLICE_STEP:   cfg_step  = data[SLICE_W-1:0];
            CFG_END_SLICE:    cfg_end   = data[SLICE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [FRAME_W-1:0] frame, input logic [SLICE_W-1:0] first,
                             input logic [SLICE_W-1:0] step, input logic [SLICE_W-1:0] last);
        write_reg(CFG_FRAME_PIXELS, frame);
        write_reg(CFG_START_SLICE, CFG_W'(first));
        write_reg(CFG_SLICE_STEP, CFG_W'(step));
        write_reg(CFG_END_SLICE, CFG_W'(last));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [VOXEL_W-1:0] pick_voxel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return VOXEL_W'($urandom_range(15));
            default: return VOXEL_W'($urandom);
        endcase
    endfunction

    // Default configuration straight out of reset, then a volume start
    task automatic test_reset_defaults();
        send_voxel(16'h0000, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'hA5A5, 1'b1);
    endtask

    // One-pixel slices from a zero frame size, zero step acting as one
    task automatic test_zero_step_min_frame();
        wait_quiet();
        configure(17'd0, 16'd0, 16'd0, 16'd3);
        send_voxel(16'h1234, 1'b1);
        send_voxel(16'h0001, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'h0000, 1'b0);
        send_voxel(16'h8000, 1'b0);
    endtask

    // No slice selected when the start lies past the end
    task automatic test_start_after_end();
        wait_quiet();
        configure(17'd2, 16'd5, 16'd1, 16'd4);
        send_voxel(16'h00FF, 1'b1);
        send_voxel(16'hFF00, 1'b0);
        send_voxel(16'h7FFF, 1'b0);
        send_voxel(16'h5555, 1'b0);
    endtask

    // Frame size above the store is cut down, widest step and end
    task automatic test_oversize_frame();
        wait_quiet();
        configure(17'h1FFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        send_voxel(16'hAAAA, 1'b1);
        send_voxel(16'h5555, 1'b0);
    endtask

    // Shrink the frame part way through a slice: the next voxel ends it
    task automatic test_frame_shrink();
        wait_quiet();
        configure(17'd6, 16'd0, 16'd1, 16'd2);
        send_voxel(16'h0010, 1'b1);
        send_voxel(16'h0020, 1'b0);
        send_voxel(16'h0030, 1'b0);
        send_voxel(16'h0040, 1'b0);
        wait_quiet();
        configure(17'd2, 16'd0, 16'd1, 16'd2);
        send_voxel(16'h0050, 1'b0);
        send_voxel(16'h0005, 1'b0);
        send_voxel(16'hFFF0, 1'b0);
    endtask

    // Mostly whole volumes under fresh settings, with stray and missing starts
    task automatic test_random_volumes(input int n_items);
        int sent, len, fr_eff;
        logic [FRAME_W-1:0] fr;
        logic [SLICE_W-1:0] st, sp, en;
        bit vs;
        sent = 0;
        while (sent < n_items) begin
            wait_quiet();
            if ($urandom_range(19) == 0) begin
                case ($urandom_range(3))
                    0:       fr = 17'd0;
                    1:       fr = 17'd65536;
                    2:       fr = 17'h1FFFF;
                    default: fr = FRAME_W'($urandom);
                endcase
            end else begin
                fr = FRAME_W'($urandom_range(1, 12));
            end
            st = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            sp = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(3));
            en = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(8));
            if ($urandom_range(3) != 0)
                configure(fr, st, sp, en);
            fr_eff = (cfg_frame == 0) ? 1 : int'(cfg_frame);
            if (fr_eff <= 12 && cfg_end <= 8)
                len = fr_eff * (cfg_end + 2) > 80 ? 80 : fr_eff * (cfg_end + 2);
            else
                len = $urandom_range(4, 40);
            for (int i = 0; i < len; i++) begin
                vs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
                send_voxel(pick_voxel(), vs);
            end
            sent += len;
        end
    endtask

    // Hold the receiver off so the core fills and stalls its input, then drain
    task automatic test_backpressure();
        wait_quiet();
        configure(17'd4, 16'd0, 16'd1, 16'hFFFF);
        hold_left = 120;
        for (int i = 0; i < 40; i++)
            send_voxel(pick_voxel(), i == 0);
        wait_quiet();
        for (int i = 0; i < 12; i++)
            send_voxel(pick_voxel(), 1'b0);
    endtask

    // Receiver: long hold-off when asked, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void check_field(input string name, input int exp_v, input logic [15:0] got);
        if (got !== exp_v[15:0]) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got);
            errors++;
        end
    endfunction

    // Compare each output transaction with the oldest projection due
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (projections_due.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, got %h", $time, o_out_data);
                errors++;
            end else begin
                exp_r = projections_due.pop_front();
                check_field("projected_value", exp_r.projected_value, o_out_data.projected_value);
                check_field("pixel_index", exp_r.pixel_index, o_out_data.pixel_index);
                check_field("final_slice", exp_r.final_slice, o_out_data.final_slice);
                check_field("last_pixel", exp_r.last_pixel, o_out_data.last_pixel);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("strided_slice_max_projection_core_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 77;
        test_reset_defaults();
        test_zero_step_min_frame();
        test_start_after_end();
        test_oversize_frame();
        test_frame_shrink();
        test_random_volumes(620);

        send_idle_pct = 77;
        recv_idle_pct = 34;
        test_random_volumes(620);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_volumes(620);

        wait_quiet();
        if (errors == 0)
            $display("strided_slice_max_projection_core_tb: clean");
        else
            $display("strided_slice_max_projection_core_tb: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/sspm_pkg.sv
rtl/strided_slice_max_projection_core.sv
sim/strided_slice_max_projection_core_tb.sv
